/* rtl/mbxd_pkg.sv */
// shared types, constants and codes for the mailbox doorbell bank
`timescale 1ns / 1ps

package mbxd_pkg;

   // field widths of the bus access and its response
   localparam int ADDR_W = 11;
   localparam int DATA_W = 64;
   localparam int LINE_W = 6;
   localparam int MODE_W = 2;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = ((ADDR_W + DATA_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_W + 1 + LINE_W + 7) / 8) * 8;

   // smallest mailbox stride; the address then splits into at most LINE_W index bits
   localparam int MIN_MAILBOX_BYTES = 32;

   // parameter defaults
   localparam int DEF_NUM_MAILBOXES = 64;
   localparam int DEF_MAILBOX_BYTES = 32;

   // access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // register offsets inside one mailbox
   localparam logic [ADDR_W-1:0] OFS_VALUE = ADDR_W'(8'h00);
   localparam logic [ADDR_W-1:0] OFS_LAC   = ADDR_W'(8'h08);
   localparam logic [ADDR_W-1:0] OFS_MASK  = ADDR_W'(8'h10);
   localparam logic [ADDR_W-1:0] OFS_FUNC  = ADDR_W'(8'h18);

   // store mode in the low bits of the function word
   localparam logic [MODE_W-1:0] MODE_OR = 2'd1;

   // decoded register select
   typedef enum logic [2:0] {
      SEL_VALUE,
      SEL_LAC,
      SEL_MASK,
      SEL_FUNC,
      SEL_NONE
   } reg_sel_type;

   // decoded bus access
   typedef struct packed {
      logic              is_write;
      logic              in_range;
      reg_sel_type       sel;
      logic [LINE_W-1:0] idx;
   } dec_type;

   // one mailbox entry as held in memory
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] mask;
      logic [DATA_W-1:0] func;
   } entry_type;

   // controller states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

/* rtl/mbxd_decode.sv */
// address split into mailbox index and register select
`timescale 1ns / 1ps

module mbxd_decode #(
   parameter int NUM_MAILBOXES = mbxd_pkg::DEF_NUM_MAILBOXES,
   parameter int MAILBOX_BYTES = mbxd_pkg::DEF_MAILBOX_BYTES
) (
   input  logic                        operation,
   input  logic [mbxd_pkg::ADDR_W-1:0] address,
   output mbxd_pkg::dec_type           dec
);

   localparam int AW = mbxd_pkg::ADDR_W;
   localparam int QW = mbxd_pkg::LINE_W;
   // reciprocal of the stride, exact for every address of AW bits
   localparam int SH = AW + $clog2(MAILBOX_BYTES);
   localparam int RW = AW + 1;
   localparam int PW = AW + RW;
   localparam logic [RW-1:0] RECIP = RW'(((1 << SH) + MAILBOX_BYTES - 1) / MAILBOX_BYTES);

   logic [PW-1:0]               prod;
   logic [mbxd_pkg::ADDR_W-1:0] rem;
   logic [QW-1:0]               quo;

   // division by the mailbox stride through a reciprocal multiply
   assign prod = PW'(address) * PW'(RECIP);
   assign quo  = QW'(prod >> SH);
   assign rem  = address - AW'(32'(quo) * 32'(MAILBOX_BYTES));

   // register offset decode
   always_comb begin
      dec.is_write = (operation == mbxd_pkg::OP_WRITE);
      dec.in_range = (32'(quo) < 32'(NUM_MAILBOXES));
      dec.idx      = quo;
      unique case (rem)
         mbxd_pkg::OFS_VALUE: dec.sel = mbxd_pkg::SEL_VALUE;
         mbxd_pkg::OFS_LAC:   dec.sel = mbxd_pkg::SEL_LAC;
         mbxd_pkg::OFS_MASK:  dec.sel = mbxd_pkg::SEL_MASK;
         mbxd_pkg::OFS_FUNC:  dec.sel = mbxd_pkg::SEL_FUNC;
         default:             dec.sel = mbxd_pkg::SEL_NONE;
      endcase
   end

endmodule

/* rtl/mbxd_ram.sv */
// mailbox entry memory, one write and one registered read port
`timescale 1ns / 1ps

module mbxd_ram #(
   parameter int NUM_MAILBOXES = mbxd_pkg::DEF_NUM_MAILBOXES,
   localparam int IDX_W = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [IDX_W-1:0]     waddr,
   input  mbxd_pkg::entry_type  wdata,
   input  logic                 re,
   input  logic [IDX_W-1:0]     raddr,
   output mbxd_pkg::entry_type  rdata
);

   mbxd_pkg::entry_type mem [NUM_MAILBOXES];
   mbxd_pkg::entry_type rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data valid the cycle after the enable
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/mbxd_ctrl.sv */
// access sequencer: clearing sweep, read-modify-write and response register
`timescale 1ns / 1ps

module mbxd_ctrl #(
   parameter int NUM_MAILBOXES = mbxd_pkg::DEF_NUM_MAILBOXES,
   localparam int IDX_W = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  mbxd_pkg::dec_type             dec,
   input  logic [mbxd_pkg::DATA_W-1:0]   write_data,
   output logic                          mem_we,
   output logic [IDX_W-1:0]              mem_waddr,
   output mbxd_pkg::entry_type           mem_wdata,
   output logic                          mem_re,
   output logic [IDX_W-1:0]              mem_raddr,
   input  mbxd_pkg::entry_type           mem_rdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [mbxd_pkg::DATA_W-1:0]   read_data,
   output logic                          irq_fire,
   output logic [mbxd_pkg::LINE_W-1:0]   irq_line
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MAILBOXES - 1);

   mbxd_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]            clr_ff, clr_in;
   mbxd_pkg::dec_type           dec_ff, dec_in;
   logic [mbxd_pkg::DATA_W-1:0] data_ff, data_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [mbxd_pkg::DATA_W-1:0] rd_ff, rd_in;
   logic                        fire_ff, fire_in;
   logic [mbxd_pkg::LINE_W-1:0] line_ff, line_in;

   logic                        req_xfer;
   logic                        proceed;
   logic                        changed;
   mbxd_pkg::entry_type         entry_new;
   logic [mbxd_pkg::DATA_W-1:0] stored;
   logic [mbxd_pkg::DATA_W-1:0] rd_val;
   logic                        fire_val;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbxd_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               state_in = mbxd_pkg::ST_IDLE;
            end
         end
         mbxd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = mbxd_pkg::ST_EXEC;
            end
         end
         mbxd_pkg::ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = mbxd_pkg::ST_IDLE;
            end
         end
         default: state_in = mbxd_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      proceed    = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = IDX_W'(dec_ff.idx);
      mem_wdata  = entry_new;
      unique case (state_ff)
         mbxd_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
         end
         mbxd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         mbxd_pkg::ST_EXEC: begin
            proceed = !rsp_valid_ff || rsp_tready;
            mem_we  = proceed && changed;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // read the addressed entry at the transfer
   assign req_xfer  = req_tvalid && req_tready;
   assign mem_re    = req_xfer;
   assign mem_raddr = IDX_W'(dec.idx);

   // store according to the function word mode
   assign stored = (mem_rdata.func[mbxd_pkg::MODE_W-1:0] == mbxd_pkg::MODE_OR)
                   ? (mem_rdata.value | data_ff) : data_ff;

   // register access on the fetched entry
   always_comb begin
      entry_new = mem_rdata;
      rd_val    = '0;
      fire_val  = 1'b0;
      changed   = 1'b0;
      if (dec_ff.in_range) begin
         if (!dec_ff.is_write) begin
            case (dec_ff.sel)
               mbxd_pkg::SEL_VALUE: rd_val = mem_rdata.value;
               mbxd_pkg::SEL_LAC: begin
                  rd_val          = mem_rdata.value;
                  entry_new.value = '0;
                  changed         = 1'b1;
               end
               mbxd_pkg::SEL_MASK: rd_val = mem_rdata.mask;
               mbxd_pkg::SEL_FUNC: rd_val = mem_rdata.func;
               default:            rd_val = '0;
            endcase
         end else begin
            case (dec_ff.sel)
               mbxd_pkg::SEL_VALUE: begin
                  fire_val        = |(data_ff & mem_rdata.mask);
                  entry_new.value = stored;
                  changed         = 1'b1;
               end
               mbxd_pkg::SEL_LAC: begin
                  entry_new.value = stored;
                  changed         = 1'b1;
               end
               mbxd_pkg::SEL_MASK: begin
                  entry_new.mask = data_ff;
                  changed        = 1'b1;
               end
               mbxd_pkg::SEL_FUNC: begin
                  entry_new.func = data_ff;
                  changed        = 1'b1;
               end
               default: changed = 1'b0;
            endcase
         end
      end
   end

   // register next values
   always_comb begin
      clr_in       = (state_ff == mbxd_pkg::ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;
      dec_in       = req_xfer ? dec : dec_ff;
      data_in      = req_xfer ? write_data : data_ff;
      rsp_valid_in = proceed ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rd_in        = proceed ? rd_val : rd_ff;
      fire_in      = proceed ? fire_val : fire_ff;
      line_in      = proceed ? (fire_val ? dec_ff.idx : '0) : line_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbxd_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dec_ff  <= dec_in;
      data_ff <= data_in;
      rd_ff   <= rd_in;
      fire_ff <= fire_in;
      line_ff <= line_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign read_data  = rd_ff;
   assign irq_fire   = fire_ff;
   assign irq_line   = line_ff;

`ifndef SYNTHESIS
   // a transfer always moves the sequencer into its execute cycle
   a_xfer_exec: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == mbxd_pkg::ST_EXEC)
      else $error("transfer not followed by execute");

   // the memory is never written while waiting for a request
   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff != mbxd_pkg::ST_IDLE)
      else $error("memory write in idle");

   // an interrupt comes only from a write, which returns no data
   a_fire_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && fire_ff |-> rd_ff == '0)
      else $error("interrupt with read data");

   // the interrupt line reads zero without a pulse
   a_line_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !fire_ff |-> line_ff == '0)
      else $error("interrupt line set without pulse");
`endif

endmodule

/* rtl/mailbox_array_doorbell.sv */
// top level of the mailbox bank with doorbell interrupts
//
// Usage: one bus access per req_ transfer, one response per access on rsp_.
// req_tuser carries the access kind (0 read, 1 write); req_tdata carries
// the byte address and the write data. The address is split into a mailbox
// index (address / MAILBOX_BYTES) and a register offset: VALUE, LAC (read
// and clear), MASK and FUNC. rsp_tdata returns the read data, the interrupt
// pulse and the mailbox line that pulsed.
// The entry memory is read at the transfer and written back in the execute
// state, so no new access is accepted until the current one leaves it. The
// response register loads at the end of the execute state.
// The response sits in an output register, so the next access is accepted
// while it waits; when the receiver stalls, a second finished access holds
// in the execute cycle until the register frees.
// After reset the block sweeps all NUM_MAILBOXES entries to zero, one per
// cycle, and accepts no request until the sweep is done.
`timescale 1ns / 1ps

module mailbox_array_doorbell #(
   parameter int NUM_MAILBOXES = mbxd_pkg::DEF_NUM_MAILBOXES,
   parameter int MAILBOX_BYTES = mbxd_pkg::DEF_MAILBOX_BYTES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             req_tuser,  // operation
   input  logic [mbxd_pkg::REQ_TDATA_W-1:0] req_tdata,  // address, write_data, zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mbxd_pkg::RSP_TDATA_W-1:0] rsp_tdata   // read_data, irq_fire, irq_line, zero pad
);

   localparam int IDX_W = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
   localparam int AW    = mbxd_pkg::ADDR_W;
   localparam int DW    = mbxd_pkg::DATA_W;
   localparam int LW    = mbxd_pkg::LINE_W;
   localparam int PAD_W = mbxd_pkg::RSP_TDATA_W - DW - 1 - LW;

   mbxd_pkg::dec_type   dec;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   mbxd_pkg::entry_type mem_wdata;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_raddr;
   mbxd_pkg::entry_type mem_rdata;
   logic [DW-1:0]       read_data;
   logic                irq_fire;
   logic [LW-1:0]       irq_line;

   // address decode
   mbxd_decode #(
      .NUM_MAILBOXES (NUM_MAILBOXES),
      .MAILBOX_BYTES (MAILBOX_BYTES)
   ) u_decode (
      .operation (req_tuser),
      .address   (req_tdata[AW-1:0]),
      .dec       (dec)
   );

   // entry memory
   mbxd_ram #(
      .NUM_MAILBOXES (NUM_MAILBOXES)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // sequencer
   mbxd_ctrl #(
      .NUM_MAILBOXES (NUM_MAILBOXES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dec        (dec),
      .write_data (req_tdata[AW+DW-1:AW]),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .read_data  (read_data),
      .irq_fire   (irq_fire),
      .irq_line   (irq_line)
   );

   // response packing
   assign rsp_tdata = {PAD_W'(0), irq_line, irq_fire, read_data};

endmodule

/* verif/mailbox_array_doorbell_tb.sv */
// self-checking testbench for the mailbox bank with doorbell interrupts
`timescale 1ns / 1ps

module mailbox_array_doorbell_tb;

   localparam int NUM_BOXES = mbxd_pkg::DEF_NUM_MAILBOXES;
   localparam int BOX_BYTES = mbxd_pkg::DEF_MAILBOX_BYTES;
   localparam int ADDR_W = mbxd_pkg::ADDR_W;
   localparam int DATA_W = mbxd_pkg::DATA_W;
   localparam int LINE_W = mbxd_pkg::LINE_W;
   localparam int MODE_W = mbxd_pkg::MODE_W;
   localparam int REQ_TDATA_W = mbxd_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = mbxd_pkg::RSP_TDATA_W;
   localparam int RUN_LIMIT_NS = 2_000_000;

   // one response as the block should return it
   typedef struct {
      logic [DATA_W-1:0] read_data;
      logic              irq_fire;
      logic [LINE_W-1:0] irq_line;
   } doorbell_resp_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic                   req_tuser;   // operation
   logic [REQ_TDATA_W-1:0] req_tdata;   // address, write_data, zero pad
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // read_data, irq_fire, irq_line, zero pad

   // shadow copy of the mailbox bank
   logic [DATA_W-1:0] shadow_value [NUM_BOXES];
   logic [DATA_W-1:0] shadow_mask  [NUM_BOXES];
   logic [DATA_W-1:0] shadow_func  [NUM_BOXES];

   doorbell_resp_type pending_responses[$];

   logic [LINE_W-1:0] hot_boxes [4];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int read_count = 0;
   int write_count = 0;
   int doorbell_count = 0;
   int checked_count = 0;

   mailbox_array_doorbell dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      mismatch_count++;
      $display("[%0t] mismatch in %s: got 0x%016h, want 0x%016h", $time, what, got, want);
   endtask

   // bank behavior for one accepted access; updates the shadow state
   function automatic doorbell_resp_type apply_bus_access(input logic op,
                                                          input logic [ADDR_W-1:0] addr,
                                                          input logic [DATA_W-1:0] data);
      doorbell_resp_type r;
      int box;
      logic [ADDR_W-1:0] ofs;
      logic or_mode;
      r.read_data = '0;
      r.irq_fire = 1'b0;
      r.irq_line = '0;
      box = addr / BOX_BYTES;
      ofs = addr % BOX_BYTES;
      if (box < NUM_BOXES) begin
         or_mode = (shadow_func[box][MODE_W-1:0] == mbxd_pkg::MODE_OR);
         if (op == mbxd_pkg::OP_READ) begin
            if (ofs == mbxd_pkg::OFS_VALUE) begin
               r.read_data = shadow_value[box];
            end else if (ofs == mbxd_pkg::OFS_LAC) begin
               r.read_data = shadow_value[box];
               shadow_value[box] = '0;
            end else if (ofs == mbxd_pkg::OFS_MASK) begin
               r.read_data = shadow_mask[box];
            end else if (ofs == mbxd_pkg::OFS_FUNC) begin
               r.read_data = shadow_func[box];
            end
         end else begin
            if (ofs == mbxd_pkg::OFS_VALUE || ofs == mbxd_pkg::OFS_LAC) begin
               // doorbell check uses the mask before the store
               if (ofs == mbxd_pkg::OFS_VALUE && (data & shadow_mask[box]) != '0) begin
                  r.irq_fire = 1'b1;
                  r.irq_line = LINE_W'(box);
               end
               shadow_value[box] = or_mode ? (shadow_value[box] | data) : data;
            end else if (ofs == mbxd_pkg::OFS_MASK) begin
               shadow_mask[box] = data;
            end else if (ofs == mbxd_pkg::OFS_FUNC) begin
               shadow_func[box] = data;
            end
         end
      end
      return r;
   endfunction

   // drive one access, wait for its transfer, then record the expected response
   task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TDATA_W'({data, addr});
      do @(posedge clock); while (!req_tready);
      pending_responses.push_back(apply_bus_access(op, addr, data));
      if (op == mbxd_pkg::OP_WRITE) write_count++;
      else read_count++;
   endtask

   function automatic logic [ADDR_W-1:0] box_addr(input int box, input logic [ADDR_W-1:0] ofs);
      return ADDR_W'(box * BOX_BYTES) + ofs;
   endfunction

   // response checker
   always @(posedge clock) begin
      doorbell_resp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata[DATA_W-1:0], '0);
         end else begin
            want = pending_responses.pop_front();
            checked_count++;
            if (rsp_tdata[DATA_W-1:0] !== want.read_data)
               report_mismatch("read_data", rsp_tdata[DATA_W-1:0], want.read_data);
            if (rsp_tdata[DATA_W] !== want.irq_fire)
               report_mismatch("irq_fire", DATA_W'(rsp_tdata[DATA_W]), DATA_W'(want.irq_fire));
            if (rsp_tdata[DATA_W+LINE_W:DATA_W+1] !== want.irq_line)
               report_mismatch("irq_line", DATA_W'(rsp_tdata[DATA_W+LINE_W:DATA_W+1]),
                               DATA_W'(want.irq_line));
            if (rsp_tdata[DATA_W] === 1'b1) doorbell_count++;
         end
      end
   end

   // first mailbox value and mask, last mailbox LAC and func read zero after reset
   task automatic test_reset_readback();
      send_access(mbxd_pkg::OP_READ, box_addr(0, mbxd_pkg::OFS_VALUE), '0);
      send_access(mbxd_pkg::OP_READ, box_addr(0, mbxd_pkg::OFS_MASK), '1);
      send_access(mbxd_pkg::OP_READ, box_addr(NUM_BOXES - 1, mbxd_pkg::OFS_LAC), '0);
      send_access(mbxd_pkg::OP_READ, box_addr(NUM_BOXES - 1, mbxd_pkg::OFS_FUNC), '1);
   endtask

   // doorbell fires only on a value write that meets the mask
   task automatic test_doorbell_pulses();
      send_access(mbxd_pkg::OP_WRITE, box_addr(5, mbxd_pkg::OFS_MASK), 64'h8000_0000_0000_0001);
      send_access(mbxd_pkg::OP_WRITE, box_addr(5, mbxd_pkg::OFS_VALUE), 64'h7fff_ffff_ffff_fffe);
      send_access(mbxd_pkg::OP_WRITE, box_addr(5, mbxd_pkg::OFS_VALUE), 64'h8000_0000_0000_0000);
      send_access(mbxd_pkg::OP_WRITE, box_addr(5, mbxd_pkg::OFS_LAC), '1);
      send_access(mbxd_pkg::OP_READ, box_addr(5, mbxd_pkg::OFS_LAC), '0);
      send_access(mbxd_pkg::OP_READ, box_addr(5, mbxd_pkg::OFS_VALUE), '0);
      send_access(mbxd_pkg::OP_WRITE, box_addr(NUM_BOXES - 1, mbxd_pkg::OFS_MASK), '1);
      send_access(mbxd_pkg::OP_WRITE, box_addr(NUM_BOXES - 1, mbxd_pkg::OFS_VALUE), 64'h1);
      send_access(mbxd_pkg::OP_WRITE, box_addr(NUM_BOXES - 1, mbxd_pkg::OFS_VALUE), '0);
   endtask

   // or mode merges, modes 2 and 3 replace
   task automatic test_store_modes();
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_FUNC), 64'h1);
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_VALUE), 64'h00ff_0000_0000_00f0);
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_LAC), 64'h0f00_0000_0000_000f);
      send_access(mbxd_pkg::OP_READ, box_addr(7, mbxd_pkg::OFS_VALUE), '0);
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_FUNC), 64'h2);
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_VALUE), 64'h1234);
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_FUNC), '1);
      send_access(mbxd_pkg::OP_WRITE, box_addr(7, mbxd_pkg::OFS_LAC), 64'h5a00);
      send_access(mbxd_pkg::OP_READ, box_addr(7, mbxd_pkg::OFS_FUNC), '0);
      send_access(mbxd_pkg::OP_READ, box_addr(7, mbxd_pkg::OFS_LAC), '0);
   endtask

   // unaligned and unused offsets read zero and ignore writes
   task automatic test_unmapped_registers();
      send_access(mbxd_pkg::OP_WRITE, box_addr(9, ADDR_W'(4)), '1);
      send_access(mbxd_pkg::OP_WRITE, 11'h7ff, '1);
      send_access(mbxd_pkg::OP_READ, box_addr(9, ADDR_W'(1)), '0);
      send_access(mbxd_pkg::OP_READ, 11'h7ff, '0);
   endtask

   // pick new mailboxes to concentrate traffic on
   task automatic refresh_hot_boxes();
      for (int i = 0; i < 4; i++) hot_boxes[i] = LINE_W'($urandom);
      if ($urandom_range(3) == 0) hot_boxes[0] = '0;
      if ($urandom_range(3) == 0) hot_boxes[1] = '1;
   endtask

   // random traffic, mostly on a few mailboxes and the four real registers
   task automatic send_random_access();
      logic op;
      logic [LINE_W-1:0] box;
      logic [4:0] ofs;
      logic [DATA_W-1:0] data;
      int pick;
      op = 1'($urandom_range(1));
      box = ($urandom_range(99) < 80) ? hot_boxes[$urandom_range(3)] : LINE_W'($urandom);
      ofs = ($urandom_range(99) < 88) ? 5'(8 * $urandom_range(3)) : 5'($urandom);
      pick = $urandom_range(99);
      if (pick < 35)      data = {$urandom, $urandom};
      else if (pick < 60) data = 64'h1 << $urandom_range(63);
      else if (pick < 75) data = shadow_mask[box] & {$urandom, $urandom};
      else if (pick < 82) data = '0;
      else if (pick < 88) data = '1;
      else                data = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      send_access(op, {box, ofs}, data);
   endtask

   task automatic run_traffic_phase(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) refresh_hot_boxes();
         // bursts with no idling on either side
         if (i % 170 == 120) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end else if (i % 170 == 150) begin
            send_idle_pct = send_pct;
            recv_stall_pct = recv_pct;
         end
         send_random_access();
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(510, 19, 46);
      run_traffic_phase(510, 46, 19);
      run_traffic_phase(510, 0, 0);
   endtask

   // main sequence
   initial begin
      for (int i = 0; i < NUM_BOXES; i++) begin
         shadow_value[i] = '0;
         shadow_mask[i]  = '0;
         shadow_func[i]  = '0;
      end
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= mbxd_pkg::OP_READ;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 19;
      recv_stall_pct = 46;
      test_reset_readback();
      test_doorbell_pulses();
      test_store_modes();
      test_unmapped_registers();
      test_random_traffic();
      req_tvalid <= 1'b0;
      recv_stall_pct = 30;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d reads and %0d writes, %0d responses checked, %0d doorbells",
               read_count, write_count, checked_count, doorbell_count);
      $display("store modes, read-and-clear, unmapped offsets and stalls on both sides");
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d responses outstanding", pending_responses.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
